// ===== hw/rtl/sprite_entry_tile_expander_assert.svh =====
// ----------------------------------------------------------------------------
// Sprite entry tile expander assertion macros
// Clocked assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SPRITE_ENTRY_TILE_EXPANDER_ASSERT_SVH
`define SPRITE_ENTRY_TILE_EXPANDER_ASSERT_SVH

`ifndef SYNTHESIS
// check prop at every clock edge outside reset
`define SPTE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("spte assertion failed");
// check that cond never holds outside reset
`define SPTE_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("spte forbidden condition seen");
`else
`define SPTE_ASSERT(lbl, clk, rst_n, prop)
`define SPTE_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ===== hw/rtl/spte_pkg.sv =====
// ----------------------------------------------------------------------------
// Sprite entry tile expander package
// Shared types, constants, and the code mask, last piece and piece layout functions.
// ----------------------------------------------------------------------------
package spte_pkg;

    localparam int unsigned QueueDepth = 2;

    localparam logic [9:0] XOffset   = 10'd40;
    localparam logic [8:0] YBase     = 9'd224;
    localparam logic [9:0] TileStepX = 10'd16;
    localparam logic [8:0] TileStepY = 9'd16;

    typedef enum logic [1:0] {
        SIZE_1X1  = 2'd0,
        SIZE_WIDE = 2'd1,
        SIZE_TALL = 2'd2,
        SIZE_BOTH = 2'd3
    } t_size;

    // classified sprite entry handed from front to back
    typedef struct packed {
        logic [7:0]        code;
        logic [7:0]        color;
        logic              fx;
        logic              fy;
        t_size             size;
        logic signed [9:0] x;
        logic signed [8:0] y;
    } t_entry;

    typedef struct packed {
        logic [1:0] off;
        logic       right;
        logic       up;
    } t_piece;

    typedef struct packed {
        logic full;
        logic avail;
    } t_qstat;

    function automatic logic [7:0] code_mask(input t_size size);
        unique case (size)
            SIZE_1X1:  code_mask = 8'hFF;
            SIZE_WIDE: code_mask = 8'hFE;
            SIZE_TALL: code_mask = 8'hFD;
            SIZE_BOTH: code_mask = 8'hFC;
            default:   code_mask = 8'hFF;
        endcase
    endfunction

    // index of the final piece for a size
    function automatic logic [1:0] last_idx(input t_size size);
        unique case (size)
            SIZE_1X1:  last_idx = 2'd0;
            SIZE_WIDE: last_idx = 2'd1;
            SIZE_TALL: last_idx = 2'd1;
            SIZE_BOTH: last_idx = 2'd3;
            default:   last_idx = 2'd0;
        endcase
    endfunction

    // layout of piece k: code offset, right shift and up shift
    function automatic t_piece piece_of(input t_size size, input logic fx,
                                        input logic fy, input logic [1:0] k);
        t_piece p;
        p = '0;
        unique case (size)
            SIZE_1X1: begin
                p = '0;
            end
            SIZE_WIDE: begin
                p.off   = {1'b0, k[0]};
                p.right = k[0] ^ fx;
                p.up    = 1'b0;
            end
            SIZE_TALL: begin
                p.off   = {k[0] ^ ~fy, 1'b0};
                p.right = 1'b0;
                p.up    = k[0];
            end
            SIZE_BOTH: begin
                p.off   = {k[1] ^ ~fy, k[0] ^ fx};
                p.right = k[0];
                p.up    = k[1];
            end
            default: begin
                p = '0;
            end
        endcase
        return p;
    endfunction

endpackage

// ===== hw/rtl/spte_front.sv =====
// ----------------------------------------------------------------------------
// Sprite entry tile expander front end
// Accepts sprite entries, drops disabled ones and computes position and code.
// ----------------------------------------------------------------------------
module spte_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [7:0]      i_sprite_code,
    input  logic [7:0]      i_color_byte,
    input  logic [7:0]      i_pos_y_raw,
    input  logic [7:0]      i_pos_x_raw,
    input  logic [7:0]      i_attributes,
    input  logic [7:0]      i_control,
    input  spte_pkg::t_qstat i_qstat,
    output logic            o_push,
    output spte_pkg::t_entry o_entry
);

    logic             r_valid;
    logic             n_valid;
    spte_pkg::t_entry r_entry;
    spte_pkg::t_entry n_entry;
    logic             accept;
    spte_pkg::t_size  size;

    assign o_stall = r_valid && i_qstat.full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_valid && !i_qstat.full;
    assign o_entry = r_entry;
    assign size    = spte_pkg::t_size'(i_attributes[3:2]);

    always_comb begin
        n_entry.size  = size;
        n_entry.fx    = i_attributes[0];
        n_entry.fy    = i_attributes[1];
        n_entry.color = i_color_byte;
        n_entry.code  = i_sprite_code & spte_pkg::code_mask(size);
        n_entry.x     = $signed({1'b0, i_control[0], i_pos_x_raw} - spte_pkg::XOffset);
        n_entry.y     = $signed(spte_pkg::YBase - {1'b0, i_pos_y_raw});
        // drop disabled entries at the door
        n_valid = (accept && !i_control[1]) || (r_valid && i_qstat.full);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_entry <= n_entry;
        end
    end

endmodule

// ===== hw/rtl/spte_queue.sv =====
// ----------------------------------------------------------------------------
// Sprite entry tile expander entry queue
// Small FIFO of classified entries between front and back.
// ----------------------------------------------------------------------------
`include "sprite_entry_tile_expander_assert.svh"

module spte_queue #(
    parameter int unsigned DEPTH = spte_pkg::QueueDepth
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  spte_pkg::t_entry i_entry,
    input  logic             i_pop,
    output spte_pkg::t_entry o_entry,
    output spte_pkg::t_qstat o_qstat
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    spte_pkg::t_entry  r_mem [DEPTH];
    logic [PtrW-1:0]   r_wr;
    logic [PtrW-1:0]   r_rd;
    logic [CntW-1:0]   r_cnt;
    logic [PtrW-1:0]   n_wr;
    logic [PtrW-1:0]   n_rd;
    logic [CntW-1:0]   n_cnt;

    assign o_qstat.full  = (r_cnt == CntW'(DEPTH));
    assign o_qstat.avail = (r_cnt != '0);
    assign o_entry       = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PtrW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PtrW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        priority if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    `SPTE_NEVER(a_push_full, i_clk, i_rst_n, i_push && o_qstat.full)
    `SPTE_NEVER(a_pop_empty, i_clk, i_rst_n, i_pop && !o_qstat.avail)
    `SPTE_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt <= CntW'(DEPTH))

endmodule

// ===== hw/rtl/spte_back.sv =====
// ----------------------------------------------------------------------------
// Sprite entry tile expander back end
// Walks the pieces of each entry and drives the tile draw output register.
// ----------------------------------------------------------------------------
`include "sprite_entry_tile_expander_assert.svh"

module spte_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spte_pkg::t_qstat  i_qstat,
    input  spte_pkg::t_entry  i_entry,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_tile_code,
    output logic [7:0]        o_color_out,
    output logic              o_flip_x,
    output logic              o_flip_y,
    output logic signed [9:0] o_screen_x,
    output logic signed [8:0] o_screen_y,
    output logic              o_last_piece
);

    spte_pkg::t_entry r_ent;
    logic             r_busy;
    logic             n_busy;
    logic [1:0]       r_k;
    logic [1:0]       n_k;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             emit;
    logic             last;
    spte_pkg::t_piece piece;

    always_comb begin
        piece = spte_pkg::piece_of(r_ent.size, r_ent.fx, r_ent.fy, r_k);
        last  = (r_k == spte_pkg::last_idx(r_ent.size));
        emit  = r_busy && (!r_out_valid || !i_stall);
        o_pop = i_qstat.avail && (!r_busy || (emit && last));

        n_busy = r_busy;
        n_k    = r_k;
        priority if (o_pop) begin
            n_busy = 1'b1;
            n_k    = '0;
        end else if (emit) begin
            n_busy = !last;
            n_k    = r_k + 1'b1;
        end
        // hold a stalled word, drop a taken one
        n_out_valid = emit || (r_out_valid && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_entry;
        end
        if (emit) begin
            o_tile_code  <= r_ent.code + {6'd0, piece.off};
            o_color_out  <= r_ent.color;
            o_flip_x     <= r_ent.fx;
            o_flip_y     <= r_ent.fy;
            o_screen_x   <= piece.right ? r_ent.x + $signed(spte_pkg::TileStepX) : r_ent.x;
            o_screen_y   <= piece.up ? r_ent.y - $signed(spte_pkg::TileStepY) : r_ent.y;
            o_last_piece <= last;
        end
    end

    assign o_valid = r_out_valid;

    `SPTE_ASSERT(a_k_range, i_clk, i_rst_n, r_busy |-> (r_k <= spte_pkg::last_idx(r_ent.size)))
    `SPTE_ASSERT(a_emit_valid, i_clk, i_rst_n, emit |=> o_valid)

endmodule

// ===== hw/rtl/sprite_entry_tile_expander.sv =====
// ----------------------------------------------------------------------------
// Sprite entry tile expander
// Expands one sprite table entry into one to four 16x16 tile draws.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  entry     in         i_valid / o_stall    sprite code, color, raw x/y, attr, ctrl
//  tile      out        o_valid / i_stall    code, color, flips, x, y, last mark
//
// An entry takes one cycle per tile draw at the output register while i_stall is low:
// four draws for a 2x2 sprite, one for 1x1; disabled entries produce nothing.
// The back end piece counter sets the rate; the front takes a word per cycle
// until the entry queue fills. Words pass the front, queue and back end registers.
// Reset is synchronous and clears all control state.
// A stall on the output holds the draw; the queue keeps the input moving.
// ----------------------------------------------------------------------------
module sprite_entry_tile_expander #(
    parameter int unsigned QUEUE_DEPTH = spte_pkg::QueueDepth
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_sprite_code,
    input  logic [7:0]        i_color_byte,
    input  logic [7:0]        i_pos_y_raw,
    input  logic [7:0]        i_pos_x_raw,
    input  logic [7:0]        i_attributes,
    input  logic [7:0]        i_control,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_tile_code,
    output logic [7:0]        o_color_out,
    output logic              o_flip_x,
    output logic              o_flip_y,
    output logic signed [9:0] o_screen_x,
    output logic signed [8:0] o_screen_y,
    output logic              o_last_piece
);

    spte_pkg::t_qstat qstat;
    spte_pkg::t_entry push_entry;
    spte_pkg::t_entry pop_entry;
    logic             push;
    logic             pop;

    spte_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_sprite_code (i_sprite_code),
        .i_color_byte  (i_color_byte),
        .i_pos_y_raw   (i_pos_y_raw),
        .i_pos_x_raw   (i_pos_x_raw),
        .i_attributes  (i_attributes),
        .i_control     (i_control),
        .i_qstat       (qstat),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    spte_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (pop_entry),
        .o_qstat (qstat)
    );

    spte_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_qstat      (qstat),
        .i_entry      (pop_entry),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_tile_code  (o_tile_code),
        .o_color_out  (o_color_out),
        .o_flip_x     (o_flip_x),
        .o_flip_y     (o_flip_y),
        .o_screen_x   (o_screen_x),
        .o_screen_y   (o_screen_y),
        .o_last_piece (o_last_piece)
    );

endmodule
